FILE: sv/utf8_to_utf16_transcoder_unit_macros.svh
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit_macros.svh
// assertion macros for the utf-8 to utf-16 transcoder; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property checked only out of reset
`define U8U16_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
// property checked at every edge, reset included
`define U8U16_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define U8U16_ASSERT(label, prop, msg)
`define U8U16_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: sv/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// types, constants and helpers shared by the utf-8 to utf-16 transcoder
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // field widths
    localparam int CountW = 31;
    localparam int UnitW  = 16;
    localparam int CpW    = 21;

    // count limits
    localparam logic [CountW-1:0] COUNT_MAX     = 31'h7FFF_FFFF;
    localparam logic [CountW-1:0] COUNT_MAX_M1  = 31'h7FFF_FFFE;
    localparam logic [CountW-1:0] MAX_UNITS_RST = 31'd2147483643;

    // code point limits
    localparam logic [CpW-1:0] CP_2B_MIN   = 21'h00080;
    localparam logic [CpW-1:0] CP_3B_MIN   = 21'h00800;
    localparam logic [CpW-1:0] CP_SUPP_MIN = 21'h10000;
    localparam logic [CpW-1:0] CP_SURR_LO  = 21'h0D800;
    localparam logic [CpW-1:0] CP_SURR_HI  = 21'h0DFFF;
    localparam logic [CpW-1:0] CP_MAX      = 21'h10FFFF;

    // surrogate bases
    localparam logic [UnitW-1:0] SURR_HI_BASE = 16'hD800;
    localparam logic [UnitW-1:0] SURR_LO_BASE = 16'hDC00;

    // lead byte boundaries
    localparam logic [7:0] BYTE_CONT_MIN = 8'h80;
    localparam logic [7:0] BYTE_LEAD2    = 8'hC0;
    localparam logic [7:0] BYTE_LEAD3    = 8'hE0;
    localparam logic [7:0] BYTE_LEAD4    = 8'hF0;
    localparam logic [7:0] BYTE_BAD      = 8'hF8;

    // character length codes (length minus one)
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_BAD = 1'b1;

    // one result item
    typedef struct packed {
        logic [UnitW-1:0]  code_unit;
        logic              has_unit;
        logic              last;
        logic              status;
        logic [CountW-1:0] unit_count;
    } result_t;

    // decoder state carried between items
    typedef struct packed {
        logic [CpW-1:0]    partial;
        logic [1:0]        pending;
        logic [1:0]        len_m1;
        logic              discarding;
        logic [CountW-1:0] units;
    } dec_state_t;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]        cnt;
        result_t [2:0]     items;
    } bundle_t;

    // occupancy of the result buffer
    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] idx;
    } buf_stat_t;

    function automatic result_t mk_unit(input logic [UnitW-1:0] unit,
                                        input logic [CountW-1:0] count);
        result_t r;
        r.code_unit  = unit;
        r.has_unit   = 1'b1;
        r.last       = 1'b0;
        r.status     = ST_OK;
        r.unit_count = count;
        return r;
    endfunction

    function automatic result_t mk_final(input logic st,
                                         input logic [CountW-1:0] count);
        result_t r;
        r.code_unit  = '0;
        r.has_unit   = 1'b0;
        r.last       = 1'b1;
        r.status     = st;
        r.unit_count = count;
        return r;
    endfunction

endpackage

FILE: sv/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// one utf-8 byte against the decoder state: next state and up to three items
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic [7:0]                   in_byte,
    input  u8u16_pkg::dec_state_t        st,
    input  logic [u8u16_pkg::CountW-1:0] max_units,
    output u8u16_pkg::dec_state_t        st_next,
    output u8u16_pkg::bundle_t           bundle
);
    import u8u16_pkg::*;

    logic              is_cont;
    logic [CpW-1:0]    pc_shift;
    logic [CpW-1:0]    cp;
    logic [1:0]        cp_len;
    logic              cp_bad;
    logic              cp_supp;
    logic [CpW-1:0]    cp_off;
    logic [CountW-1:0] inc1;
    logic [CountW-1:0] inc2;
    logic              hit1;
    logic              hit2;

    // continuation byte and shifted partial character
    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign pc_shift = {st.partial[CpW-7:0], in_byte[5:0]};

    // character to emit: completed multi-byte one or a plain ascii byte
    assign cp     = (st.pending != 2'd0) ? pc_shift : {13'd0, in_byte};
    assign cp_len = (st.pending != 2'd0) ? st.len_m1 : LEN_1;

    // overlong, surrogate and range checks
    assign cp_bad = ((cp_len == LEN_2) && (cp < CP_2B_MIN))
                 || ((cp_len == LEN_3) && (cp < CP_3B_MIN))
                 || ((cp_len == LEN_4) && (cp < CP_SUPP_MIN))
                 || ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI))
                 || (cp > CP_MAX);
    assign cp_supp = (cp >= CP_SUPP_MIN);
    assign cp_off  = cp - CP_SUPP_MIN;

    // saturating unit counts after one and after two units
    assign inc1 = (st.units == COUNT_MAX) ? COUNT_MAX : st.units + 31'd1;
    assign inc2 = (st.units >= COUNT_MAX_M1) ? COUNT_MAX : st.units + 31'd2;
    assign hit1 = (inc1 >= max_units);
    assign hit2 = (inc2 >= max_units);

    // byte classification and item building
    always_comb begin
        dec_state_t clr;
        clr            = '0;
        st_next        = st;
        bundle         = '0;

        if (st.discarding) begin
            // dropping up to the next zero byte
            if (in_byte == 8'd0) begin
                st_next = clr;
            end
        end else if ((st.pending != 2'd0) && !is_cont) begin
            // bad continuation; a zero byte also ends the string
            bundle.cnt         = 2'd1;
            bundle.items[0]    = mk_final(ST_BAD, st.units);
            st_next            = clr;
            st_next.discarding = (in_byte != 8'd0);
        end else if (st.pending > 2'd1) begin
            // more continuation bytes to come
            st_next.partial = pc_shift;
            st_next.pending = st.pending - 2'd1;
        end else if ((st.pending == 2'd1) || ((in_byte != 8'd0) && !in_byte[7])) begin
            // complete character
            st_next.partial = '0;
            st_next.pending = 2'd0;
            st_next.len_m1  = LEN_1;
            if (cp_bad) begin
                bundle.cnt         = 2'd1;
                bundle.items[0]    = mk_final(ST_BAD, st.units);
                st_next            = clr;
                st_next.discarding = 1'b1;
            end else if (cp_supp) begin
                bundle.items[0] = mk_unit(SURR_HI_BASE | {6'd0, cp_off[19:10]}, inc1);
                bundle.items[1] = mk_unit(SURR_LO_BASE | {6'd0, cp_off[9:0]}, inc2);
                st_next.units   = inc2;
                if (hit2) begin
                    bundle.cnt         = 2'd3;
                    bundle.items[2]    = mk_final(ST_OK, inc2);
                    st_next            = clr;
                    st_next.discarding = 1'b1;
                end else begin
                    bundle.cnt = 2'd2;
                end
            end else begin
                bundle.items[0] = mk_unit(cp[UnitW-1:0], inc1);
                st_next.units   = inc1;
                if (hit1) begin
                    bundle.cnt         = 2'd2;
                    bundle.items[1]    = mk_final(ST_OK, inc1);
                    st_next            = clr;
                    st_next.discarding = 1'b1;
                end else begin
                    bundle.cnt = 2'd1;
                end
            end
        end else if (in_byte == 8'd0) begin
            // end of string
            bundle.cnt      = 2'd1;
            bundle.items[0] = mk_final(ST_OK, st.units);
            st_next         = clr;
        end else if (in_byte < BYTE_LEAD2) begin
            // stray continuation byte
            bundle.cnt         = 2'd1;
            bundle.items[0]    = mk_final(ST_BAD, st.units);
            st_next            = clr;
            st_next.discarding = 1'b1;
        end else if (in_byte < BYTE_LEAD3) begin
            st_next.partial = {16'd0, in_byte[4:0]};
            st_next.pending = 2'd1;
            st_next.len_m1  = LEN_2;
        end else if (in_byte < BYTE_LEAD4) begin
            st_next.partial = {17'd0, in_byte[3:0]};
            st_next.pending = 2'd2;
            st_next.len_m1  = LEN_3;
        end else if (in_byte < BYTE_BAD) begin
            st_next.partial = {18'd0, in_byte[2:0]};
            st_next.pending = 2'd3;
            st_next.len_m1  = LEN_4;
        end else begin
            // lead byte out of range
            bundle.cnt         = 2'd1;
            bundle.items[0]    = mk_final(ST_BAD, st.units);
            st_next            = clr;
            st_next.discarding = 1'b1;
        end
    end

endmodule

FILE: sv/u8u16_result_buf.sv
// ----------------------------------------------------------------------------
// u8u16_result_buf
// holds the items of one decoded byte and hands them out one per cycle while m_ready is high
// ----------------------------------------------------------------------------
module u8u16_result_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  u8u16_pkg::bundle_t   bundle,
    output logic                 free,
    output u8u16_pkg::buf_stat_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u8u16_pkg::result_t   m_item
);
    import u8u16_pkg::*;

    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    result_t [2:0] items_reg;
    logic          pop;
    logic          pop_last;

    assign m_valid  = (cnt_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign pop_last = pop && (idx_reg == cnt_reg - 2'd1);
    assign free     = !m_valid || pop_last;
    assign stat     = '{cnt: cnt_reg, idx: idx_reg};

    // occupancy update
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = bundle.cnt;
            idx_next = 2'd0;
        end else if (pop_last) begin
            cnt_next = 2'd0;
            idx_next = 2'd0;
        end else if (pop) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (load) begin
            items_reg <= bundle.items;
        end
    end

    // output select
    always_comb begin
        case (idx_reg)
            2'd1:    m_item = items_reg[1];
            2'd2:    m_item = items_reg[2];
            default: m_item = items_reg[0];
        endcase
    end

endmodule

FILE: sv/utf8_to_utf16_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// utf-8 byte stream in, utf-16 code units and a final status item out
// ----------------------------------------------------------------------------
//  channel  | direction | ports
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | s_valid, s_ready, s_in_byte
//  m_       | out       | m_valid, m_ready, m_code_unit, m_has_unit,
//           |           | m_last, m_status, m_unit_count
//  cfg_     | in        | cfg_wr_en, cfg_wr_data (max_units)
//
// a byte waits in the input register until the result buffer has room and is
// decoded on the way into the result buffer; its items appear on the next cycle
// one byte per cycle when each byte gives at most one item and m_ready stays high;
// a byte with two or three items holds the input while the buffer drains
// reset clears the decoder state, both buffers and sets max_units to 2147483643
// a stall on m_ready backs up through the result buffer into s_ready
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_unit_macros.svh"

module utf8_to_utf16_transcoder_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_in_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [u8u16_pkg::UnitW-1:0]  m_code_unit,
    output logic                         m_has_unit,
    output logic                         m_last,
    output logic                         m_status,
    output logic [u8u16_pkg::CountW-1:0] m_unit_count,
    input  logic                         cfg_wr_en,
    input  logic [u8u16_pkg::CountW-1:0] cfg_wr_data
);
    import u8u16_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    dec_state_t        st_reg;
    dec_state_t        st_next;
    logic [CountW-1:0] max_units_reg;
    bundle_t           bundle;
    logic              buf_free;
    buf_stat_t         buf_stat;
    result_t           m_item;
    logic              advance;

    // move the held byte into the result buffer when it has room
    assign advance = in_valid_reg && buf_free;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // decoder state and unit limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            max_units_reg <= MAX_UNITS_RST;
        end else begin
            if (advance) begin
                st_reg <= st_next;
            end
            if (cfg_wr_en) begin
                max_units_reg <= cfg_wr_data;
            end
        end
    end

    u8u16_decode u_decode (
        .in_byte   (in_byte_reg),
        .st        (st_reg),
        .max_units (max_units_reg),
        .st_next   (st_next),
        .bundle    (bundle)
    );

    u8u16_result_buf u_result_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .bundle  (bundle),
        .free    (buf_free),
        .stat    (buf_stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // result fields
    assign m_code_unit  = m_item.code_unit;
    assign m_has_unit   = m_item.has_unit;
    assign m_last       = m_item.last;
    assign m_status     = m_item.status;
    assign m_unit_count = m_item.unit_count;

    // checks
    `U8U16_ASSERT(a_idx_in_range, buf_stat.cnt != 2'd0 |-> buf_stat.idx < buf_stat.cnt, "result index beyond item count")
    `U8U16_ASSERT(a_final_is_last, m_valid && m_last |-> buf_stat.idx + 2'd1 == buf_stat.cnt, "final item not last of its byte")
    `U8U16_ASSERT(a_drop_no_pending, st_reg.discarding |-> st_reg.pending == 2'd0, "character open while dropping")
    `U8U16_ASSERT(a_unit_count_nonzero, m_valid && m_has_unit |-> m_unit_count != '0, "unit item with zero count")
    `U8U16_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid && s_ready, "buffers not empty after reset")

endmodule

FILE: tb/utf8_to_utf16_transcoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit_tb
// feeds utf-8 strings byte by byte, decodes them alongside the block and
// checks every utf-16 unit and string-end item against that expectation
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit_tb;
    import u8u16_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 6;
    localparam int PRINT_LIMIT      = 40;
    localparam int RANDOM_PER_PHASE = 25;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [7:0]        s_in_byte   = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [UnitW-1:0]  m_code_unit;
    logic              m_has_unit;
    logic              m_last;
    logic              m_status;
    logic [CountW-1:0] m_unit_count;
    logic              cfg_wr_en   = 1'b0;
    logic [CountW-1:0] cfg_wr_data = '0;

    utf8_to_utf16_transcoder_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_unit  (m_code_unit),
        .m_has_unit   (m_has_unit),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_unit_count (m_unit_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // decoder shadow state
    logic [CpW-1:0]    cp_acc;
    logic [1:0]        cont_left;
    int                seq_len;
    logic              dropping;
    logic [CountW-1:0] unit_tally;
    logic [CountW-1:0] unit_limit;

    result_t    expected_units [$];
    logic [7:0] byte_q [$];
    result_t    head_want;

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int units_seen     = 0;
    int ends_seen      = 0;
    int bad_ends_seen  = 0;
    int limits_used    = 0;
    int idle_cycles    = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    bit calm           = 1'b0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic push_result(input logic [UnitW-1:0] unit, input logic has,
                               input logic lst, input logic st);
        result_t r;
        r.code_unit  = unit;
        r.has_unit   = has;
        r.last       = lst;
        r.status     = st;
        r.unit_count = unit_tally;
        expected_units.push_back(r);
    endtask

    task automatic start_string();
        cp_acc     = '0;
        cont_left  = '0;
        seq_len    = 0;
        unit_tally = '0;
    endtask

    // string-end item; a zero byte starts the next string, anything else starts dropping
    task automatic close_string(input logic st, input logic by_zero);
        push_result('0, 1'b0, 1'b1, st);
        start_string();
        dropping = !by_zero;
    endtask

    task automatic count_unit();
        if (unit_tally != COUNT_MAX)
            unit_tally++;
    endtask

    // finished character: legality, one unit or a surrogate pair, then the limit
    task automatic emit_code_point(input logic [CpW-1:0] cp);
        logic           bad;
        logic [CpW-1:0] v;
        bad = (seq_len == 2 && cp < CP_2B_MIN) || (seq_len == 3 && cp < CP_3B_MIN) ||
              (seq_len == 4 && cp < CP_SUPP_MIN) ||
              (cp >= CP_SURR_LO && cp <= CP_SURR_HI) || (cp > CP_MAX);
        cp_acc  = '0;
        seq_len = 0;
        if (bad) begin
            close_string(ST_BAD, 1'b0);
        end else begin
            if (cp >= CP_SUPP_MIN) begin
                v = cp - CP_SUPP_MIN;
                count_unit();
                push_result(SURR_HI_BASE | UnitW'(v[19:10]), 1'b1, 1'b0, ST_OK);
                count_unit();
                push_result(SURR_LO_BASE | UnitW'(v[9:0]), 1'b1, 1'b0, ST_OK);
            end else begin
                count_unit();
                push_result(cp[UnitW-1:0], 1'b1, 1'b0, ST_OK);
            end
            if (unit_tally >= unit_limit)
                close_string(ST_OK, 1'b0);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        if (dropping) begin
            if (b == 8'h00) begin
                dropping = 1'b0;
                start_string();
            end
        end else if (cont_left != 0) begin
            if (b < BYTE_CONT_MIN || b >= BYTE_LEAD2) begin
                close_string(ST_BAD, b == 8'h00);
            end else begin
                cp_acc = {cp_acc[CpW-7:0], b[5:0]};
                cont_left--;
                if (cont_left == 0)
                    emit_code_point(cp_acc);
            end
        end else if (b == 8'h00) begin
            close_string(ST_OK, 1'b1);
        end else if (b < BYTE_CONT_MIN) begin
            seq_len = 1;
            emit_code_point(CpW'(b));
        end else if (b < BYTE_LEAD2) begin
            close_string(ST_BAD, 1'b0);
        end else if (b < BYTE_LEAD3) begin
            cp_acc    = CpW'(b[4:0]);
            cont_left = 2'd1;
            seq_len   = 2;
        end else if (b < BYTE_LEAD4) begin
            cp_acc    = CpW'(b[3:0]);
            cont_left = 2'd2;
            seq_len   = 3;
        end else if (b < BYTE_BAD) begin
            cp_acc    = CpW'(b[2:0]);
            cont_left = 2'd3;
            seq_len   = 4;
        end else begin
            close_string(ST_BAD, 1'b0);
        end
    endtask

    // utf-8 encoding of cp in len bytes, overlong allowed; only the first keep go out
    task automatic push_encoded(input logic [CpW-1:0] cp, input int len, input int keep);
        logic [7:0] enc [4];
        case (len)
            1: begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            byte_q.push_back(enc[i]);
    endtask

    // mostly clean strings of random characters, some with broken sequences
    task automatic queue_random_text(input int quota);
        int start_size;
        int n_chars;
        int pick;
        int len;
        bit clean;
        start_size = byte_q.size();
        while (byte_q.size() - start_size < quota) begin
            clean   = ($urandom_range(0, 9) < 7);
            n_chars = $urandom_range(0, 6);
            for (int c = 0; c < n_chars; c++) begin
                pick = clean ? $urandom_range(0, 84) : $urandom_range(0, 99);
                if (pick < 30) begin
                    push_encoded(CpW'($urandom_range(1, 'h7F)), 1, 1);
                end else if (pick < 50) begin
                    push_encoded(CpW'($urandom_range('h80, 'h7FF)), 2, 2);
                end else if (pick < 68) begin
                    push_encoded(CpW'($urandom_range('h800, 'hFFFF)), 3, 3);
                end else if (pick < 85) begin
                    push_encoded(CpW'($urandom_range('h10000, 'h10FFFF)), 4, 4);
                end else if (pick < 87) begin
                    // overlong form
                    len = $urandom_range(2, 4);
                    push_encoded(CpW'($urandom_range(0, (len == 2) ? 'h7F :
                                                   (len == 3) ? 'h7FF : 'hFFFF)), len, len);
                end else if (pick < 89) begin
                    push_encoded(CpW'($urandom_range('hD800, 'hDFFF)), 3, 3);
                end else if (pick < 91) begin
                    // above the unicode range
                    push_encoded(CpW'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
                end else if (pick < 92) begin
                    byte_q.push_back(8'($urandom_range('h80, 'hBF)));
                end else if (pick < 94) begin
                    byte_q.push_back(8'($urandom_range('hF8, 'hFF)));
                end else if (pick < 97) begin
                    // truncated character
                    len = $urandom_range(2, 4);
                    push_encoded(CpW'($urandom_range(0, 'h1FFFFF)), len,
                                 $urandom_range(1, len - 1));
                end else begin
                    byte_q.push_back(8'($urandom_range(1, 255)));
                end
            end
            byte_q.push_back(8'h00);
        end
    endtask

    task automatic write_limit(input logic [CountW-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        unit_limit   = value;
        limits_used++;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sender drained and nothing outstanding, then let the pipeline go quiet
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (byte_q.size() != 0 || s_valid || expected_units.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // byte driver with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (byte_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    s_valid <= 1'b0;
                end else begin
                    s_valid   <= 1'b1;
                    s_in_byte <= byte_q.pop_front();
                end
            end
        end
    end

    // result monitor with random stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_units.size() == 0) begin
                report_mismatch("item with nothing expected", m_unit_count, 0);
            end else begin
                head_want = expected_units.pop_front();
                if (m_code_unit !== head_want.code_unit)
                    report_mismatch("code_unit", m_code_unit, head_want.code_unit);
                if (m_has_unit !== head_want.has_unit)
                    report_mismatch("has_unit", m_has_unit, head_want.has_unit);
                if (m_last !== head_want.last)
                    report_mismatch("last", m_last, head_want.last);
                if (m_status !== head_want.status)
                    report_mismatch("status", m_status, head_want.status);
                if (m_unit_count !== head_want.unit_count)
                    report_mismatch("unit_count", m_unit_count, head_want.unit_count);
                if (head_want.has_unit) begin
                    units_seen++;
                end else begin
                    ends_seen++;
                    if (head_want.status == ST_BAD)
                        bad_ends_seen++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        logic [CountW-1:0] later_limits [4];
        dropping   = 1'b0;
        unit_limit = MAX_UNITS_RST;
        start_string();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limit: empty string, character sizes and their edges, each error kind but overlong
        write_limit(MAX_UNITS_RST);
        @(negedge aclk);
        byte_q = {8'h00,
                  8'h41, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
                  8'h80, 8'h00,
                  8'hF8, 8'h00,
                  8'hED, 8'hA0, 8'h80, 8'h00,
                  8'hF4, 8'h90, 8'h80, 8'h80, 8'h00,
                  8'hC3, 8'h00};
        queue_random_text(RANDOM_PER_PHASE);

        // limit of two: a surrogate pair carries the count one past it
        wait_idle();
        write_limit(31'd2);
        @(negedge aclk);
        byte_q = {8'h61, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00};
        queue_random_text(RANDOM_PER_PHASE);

        // zero acts as one, then one, a small random limit, and back to the reset limit
        later_limits[0] = '0;
        later_limits[1] = 31'd1;
        later_limits[2] = CountW'($urandom_range(3, 12));
        later_limits[3] = MAX_UNITS_RST;
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            if (p == 3)
                calm = 1'b1;
            write_limit(later_limits[p]);
            @(negedge aclk);
            queue_random_text(RANDOM_PER_PHASE);
        end

        wait_idle();
        $display("%0d bytes decoded under %0d unit limits", bytes_sent, limits_used);
        $display("%0d code units and %0d string ends checked, %0d of them bad",
                 units_seen, ends_seen, bad_ends_seen);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/u8u16_pkg.sv
sv/u8u16_decode.sv
sv/u8u16_result_buf.sv
sv/utf8_to_utf16_transcoder_unit.sv
tb/utf8_to_utf16_transcoder_unit_tb.sv
